// ===== hw/rtl/xoshiro_range_generator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the xoshiro range generator unit
// Shared concurrent check forms, all disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef XOSHIRO_RANGE_GENERATOR_UNIT_ASSERT_SVH
`define XOSHIRO_RANGE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define XRG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XRG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/xrg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrg_pkg
// Types and constants shared by the range generator front end, queue and
// generator engine.
// ---------------------------------------------------------------------------
package xrg_pkg;

  localparam int WordW        = 64;
  localparam int WarmCntW     = 5;
  localparam int DefWarmup    = 16;
  localparam int DefQueueDepth = 2;
  localparam logic [WordW-1:0] SeedFill = 64'h0000_0000_0000_00ff;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    MODE_FRACTION = 2'd0,
    MODE_RAW      = 2'd1,
    MODE_BOUNDED  = 2'd2,
    MODE_RESEED   = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_SEED_FIRST  = 1'b0,
    REG_SEED_SECOND = 1'b1
  } reg_idx_e;

  // A classified request as it waits in the queue.
  typedef struct packed {
    mode_e            mode;
    logic             err;
    logic [WordW-1:0] low;
    logic [WordW-1:0] span;
    logic [WordW-1:0] mask;
  } req_t;

endpackage

// ===== hw/rtl/xoshiro_range_generator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro_range_generator_unit
// xoshiro256** generator returning fractions, raw words or bounded integers.
// ---------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the mode, tdata the
// signed lower bound (low 64 bits) and upper bound (high 64 bits). Each
// request gives exactly one result on m_axis: tdata is the value, tuser the
// range error flag. Seeds are written through cfg_we_i / cfg_index_i /
// cfg_wdata_i and take effect on the next reseed; the user is bound to write
// them only while the unit is idle, which the block itself does not enforce.
// A request passes the front-end stage register and a short queue. The
// engine pops it when idle, draws a word and evaluates it; a rejected
// bounded draw is redrawn, and a reseed loads the seeds and runs
// WARMUP_ROUNDS warmup steps, the generator advancing one step per cycle.
// The engine serves one request at a time, while the front stage and queue
// keep taking requests; a result sits in the output register until taken.
// After reset the generator state is loaded from zero seeds and the engine
// runs WARMUP_ROUNDS warmup steps before it serves the queue; requests are
// still taken into the queue meanwhile. A stalled receiver holds the output
// register; the queue and front stage then fill and s_axis_tready drops.
// ---------------------------------------------------------------------------
module xoshiro_range_generator_unit
  import xrg_pkg::*;
#(
  parameter int WARMUP_ROUNDS = DefWarmup,
  parameter int QUEUE_DEPTH   = DefQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // range_low [63:0], range_high [127:64]
  input  logic [1:0]   s_axis_tuser,  // mode [1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // value [63:0]
  output logic [0:0]   m_axis_tuser,  // range_error [0]
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [63:0]  cfg_wdata_i
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  req_t push_req, pop_req;

  xrg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (mode_e'(s_axis_tuser)),
    .in_low_i     (s_axis_tdata[63:0]),
    .in_high_i    (s_axis_tdata[127:64]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req)
  );

  xrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  xrg_engine #(
    .WARMUP_ROUNDS (WARMUP_ROUNDS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (reg_idx_e'(cfg_index_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_req_i   (pop_req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_err_o   (m_axis_tuser[0])
  );

endmodule

// ===== hw/rtl/xrg_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrg_front
// Accepts requests, computes the bounded span, range error and rejection
// mask, and hands the classified request to the queue.
// ---------------------------------------------------------------------------
module xrg_front
  import xrg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  mode_e                   in_mode_i,
  input  logic signed [WordW-1:0] in_low_i,
  input  logic signed [WordW-1:0] in_high_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output req_t                    push_req_o
);

  logic             valid_q, valid_d;
  mode_e            mode_q;
  logic             err_q;
  logic [WordW-1:0] low_q;
  logic [WordW-1:0] span_q;
  logic [WordW-1:0] mask;
  logic             load;

  assign in_ready_o = !valid_q || push_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Stage occupancy.
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Span and bound check are taken with the request.
  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q <= in_mode_i;
      low_q  <= in_low_i;
      span_q <= in_high_i - in_low_i;
      err_q  <= (in_low_i > in_high_i);
    end
  end

  // Smear the span down from its top set bit. A span of the form 2^k-1
  // is its own mask, so a masked draw then never needs a retry.
  always_comb begin
    mask = span_q;
    mask = mask | (mask >> 1);
    mask = mask | (mask >> 2);
    mask = mask | (mask >> 4);
    mask = mask | (mask >> 8);
    mask = mask | (mask >> 16);
    mask = mask | (mask >> 32);
  end

  assign push_valid_o    = valid_q;
  assign push_req_o.mode = mode_q;
  assign push_req_o.err  = err_q;
  assign push_req_o.low  = low_q;
  assign push_req_o.span = span_q;
  assign push_req_o.mask = mask;

endmodule

// ===== hw/rtl/xrg_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xrg_queue
// Short request queue between the front end and the generator engine.
// ---------------------------------------------------------------------------
module xrg_queue
  import xrg_pkg::*;
#(
  parameter int DEPTH = DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  req_t push_req_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output req_t pop_req_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  req_t            entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ===== hw/rtl/xrg_engine.sv =====
`timescale 1ns / 1ps
`include "xoshiro_range_generator_unit_assert.svh"
// ---------------------------------------------------------------------------
// xrg_engine
// Generator state, seed registers, request sequencer and result register.
// ---------------------------------------------------------------------------
module xrg_engine
  import xrg_pkg::*;
#(
  parameter int WARMUP_ROUNDS = DefWarmup
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  reg_idx_e         cfg_index_i,
  input  logic [WordW-1:0] cfg_wdata_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  req_t             pop_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] out_value_o,
  output logic             out_err_o
);

  localparam logic [WarmCntW-1:0] WarmStart = WarmCntW'(WARMUP_ROUNDS);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_EVAL = 5'b00100,
    S_WARM = 5'b01000,
    S_HOLD = 5'b10000
  } fsm_e;

  fsm_e                fsm_q, fsm_d;
  logic [WordW-1:0]    st_q [4];
  logic [WordW-1:0]    st_d [4];
  logic [WordW-1:0]    nxt [4];
  logic [WordW-1:0]    word_q, word_d, word;
  logic [WarmCntW-1:0] cnt_q, cnt_d;
  req_t                cur_q, cur_d;
  logic [WordW-1:0]    seed0_q, seed1_q;
  logic                out_valid_q, out_valid_d;
  logic [WordW-1:0]    out_value_q;
  logic                out_err_q;
  logic                out_free, out_load;
  logic [WordW-1:0]    w2, w3, t5, rot, r, bnd_val, res_value;
  logic                fits, retry, res_err;

  // One xoshiro256** step and its output word. The multiplies by 5 and 9
  // are shift-and-add.
  always_comb begin
    w2     = st_q[2] ^ st_q[0];
    w3     = st_q[3] ^ st_q[1];
    nxt[0] = st_q[0] ^ w3;
    nxt[1] = st_q[1] ^ w2;
    nxt[2] = w2 ^ (st_q[1] << 17);
    nxt[3] = {w3[18:0], w3[63:19]};
    t5     = st_q[1] + {st_q[1][61:0], 2'b00};
    rot    = {t5[56:0], t5[63:57]};
    word   = rot + {rot[60:0], 3'b000};
  end

  // Result of the current request from the registered draw.
  always_comb begin
    r       = word_q & cur_q.mask;
    fits    = (r <= cur_q.span);
    bnd_val = r + cur_q.low;
    retry   = (cur_q.mode == MODE_BOUNDED) && !cur_q.err && !fits;
    res_err = (cur_q.mode == MODE_BOUNDED) && cur_q.err;
    case (cur_q.mode)
      MODE_FRACTION: res_value = {11'd0, word_q[63:11]};
      MODE_RAW:      res_value = word_q;
      MODE_BOUNDED:  res_value = cur_q.err ? '0 : bnd_val;
      default:       res_value = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Request sequencer.
  always_comb begin
    fsm_d       = fsm_q;
    st_d        = st_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    pop_ready_o = 1'b0;
    out_load    = 1'b0;
    case (fsm_q)
      S_INIT: begin
        if (cnt_q != '0) begin
          st_d  = nxt;
          cnt_d = cnt_q - 1'b1;
        end else begin
          fsm_d = S_IDLE;
        end
      end
      S_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          cur_d = pop_req_i;
          if (pop_req_i.mode == MODE_RESEED) begin
            st_d[0] = seed0_q;
            st_d[1] = SeedFill;
            st_d[2] = seed1_q;
            st_d[3] = '0;
            cnt_d   = WarmStart;
            fsm_d   = S_WARM;
          end else begin
            st_d   = nxt;
            word_d = word;
            fsm_d  = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (retry) begin
          st_d   = nxt;
          word_d = word;
        end else begin
          fsm_d = S_HOLD;
        end
      end
      S_WARM: begin
        if (cnt_q != '0) begin
          st_d  = nxt;
          cnt_d = cnt_q - 1'b1;
        end else begin
          fsm_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          fsm_d    = S_IDLE;
        end
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q   <= S_INIT;
      st_q[0] <= '0;
      st_q[1] <= SeedFill;
      st_q[2] <= '0;
      st_q[3] <= '0;
      cnt_q   <= WarmStart;
    end else begin
      fsm_q <= fsm_d;
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cur_q  <= cur_d;
  end

  // Seed registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed0_q <= '0;
      seed1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SEED_FIRST:  seed0_q <= cfg_wdata_i;
        REG_SEED_SECOND: seed1_q <= cfg_wdata_i;
        default:         seed0_q <= seed0_q;
      endcase
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_value;
      out_err_q   <= res_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_err_o   = out_err_q;

  // Checks on the sequencer.
  `XRG_ASSERT_SAME(a_load_free, clk_i, rst_ni, out_load, out_free, "result overwritten")
  `XRG_ASSERT_SAME(a_bounded_fits, clk_i, rst_ni,
    (fsm_q == S_HOLD) && (cur_q.mode == MODE_BOUNDED) && !cur_q.err, fits,
    "bounded draw out of span")
  `XRG_ASSERT_NEXT(a_warm_count, clk_i, rst_ni,
    ((fsm_q == S_WARM) || (fsm_q == S_INIT)) && (cnt_q != '0),
    cnt_q == $past(cnt_q) - 1'b1, "warmup count skipped")
  `XRG_ASSERT_SAME(a_pop_idle, clk_i, rst_ni, pop_ready_o, fsm_q == S_IDLE,
    "queue popped while busy")

endmodule

// ===== bench/xoshiro_range_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro_range_generator_unit_tb
// Self-checking bench for the xoshiro256** range generator unit.
// ---------------------------------------------------------------------------
// A table of directed requests comes first. Random requests follow in four
// phases that differ in sender and receiver idling, each under its own pair
// of seeds. A software copy of the generator tracks every accepted request
// and predicts its result. Each result on the output stream is compared
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module xoshiro_range_generator_unit_tb;
  import xrg_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 200;
  localparam int PhaseItems    = 370;
  localparam int DirectedCount = 22;
  localparam logic [63:0] Ones = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MinS = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxS = 64'h7fff_ffff_ffff_ffff;

  // One predicted result.
  typedef struct {
    logic [63:0] value;
    logic        range_error;
  } draw_result_t;

  // One directed request, with a typed expectation where it is obvious.
  typedef struct {
    mode_e       mode;
    logic [63:0] low;
    logic [63:0] high;
    bit          typed;
    logic [63:0] value;
    bit          range_error;
  } request_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // range_low [63:0], range_high [127:64]
  logic [1:0]   s_axis_tuser;   // mode [1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // value [63:0]
  logic [0:0]   m_axis_tuser;   // range_error [0]
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [63:0]  cfg_wdata_i;

  // Generator copy, seed registers and results still owed by the block.
  logic [63:0]  xs_state [4];
  logic [63:0]  seed_mirror [2];
  draw_result_t owed_results [$];

  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  request_row_t directed_rows [DirectedCount];

  xoshiro_range_generator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] rotl64(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Advance the generator copy by one step and return its output word.
  function automatic logic [63:0] xs_next();
    logic [63:0] s0, s1, s2, s3, word;
    s0 = xs_state[0];
    s1 = xs_state[1];
    s2 = xs_state[2] ^ s0;
    s3 = xs_state[3] ^ s1;
    word = rotl64(s1 * 64'd5, 7) * 64'd9;
    xs_state[0] = s0 ^ s3;
    xs_state[1] = s1 ^ s2;
    xs_state[2] = s2 ^ (s1 << 17);
    xs_state[3] = rotl64(s3, 45);
    return word;
  endfunction

  // Load the generator copy from two seeds and discard the warmup words.
  function automatic void xs_load(logic [63:0] a, logic [63:0] b);
    xs_state[0] = a;
    xs_state[1] = SeedFill;
    xs_state[2] = b;
    xs_state[3] = '0;
    repeat (DefWarmup) void'(xs_next());
  endfunction

  // Work out the result of one request and advance the generator copy.
  function automatic draw_result_t predict_request(mode_e m, logic [63:0] lo,
                                                   logic [63:0] hi);
    draw_result_t r;
    logic [63:0] word, span, mask, pick;
    r.value = '0;
    r.range_error = 1'b0;
    case (m)
      MODE_FRACTION: r.value = xs_next() >> 11;
      MODE_RAW:      r.value = xs_next();
      MODE_BOUNDED: begin
        word = xs_next();
        if ($signed(lo) > $signed(hi)) begin
          r.range_error = 1'b1;
        end else begin
          span = hi - lo;
          if ((span & (span + 64'd1)) == '0) begin
            // A span of the form 2^k-1 masks the first word directly.
            pick = word & span;
          end else begin
            // Smear the span into a mask and redraw until in range.
            mask = span;
            for (int sh = 1; sh < 64; sh = sh * 2) mask = mask | (mask >> sh);
            pick = word & mask;
            while (pick > span) pick = xs_next() & mask;
          end
          r.value = pick + lo;
        end
      end
      default: xs_load(seed_mirror[REG_SEED_FIRST], seed_mirror[REG_SEED_SECOND]);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Offer one request after a random gap and record its expectation once the
  // transfer happens. Returns at the rising edge of the transfer.
  task automatic send_request(mode_e m, logic [63:0] lo, logic [63:0] hi,
                              bit typed, logic [63:0] tv, bit te);
    draw_result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    s_axis_tuser  <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_request(m, lo, hi);
    if (typed) begin
      r.value = tv;
      r.range_error = te;
    end
    owed_results.push_back(r);
  endtask

  // Drop the request stream and wait until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DefWarmup + 8) @(posedge clk_i);
  endtask

  task automatic write_seed(reg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_mirror[idx] = data;
  endtask

  // Random request: mostly bounded ranges of varied span.
  task automatic send_random_request();
    int          pick;
    int          k;
    logic [63:0] lo, hi, span;
    pick = $urandom_range(99);
    lo = ($urandom_range(2) == 0) ? 64'($signed($urandom_range(2000)) - 1000) : rand64();
    hi = rand64();
    if (pick < 18) begin
      send_request(MODE_FRACTION, lo, hi, 1'b0, '0, 1'b0);
    end else if (pick < 36) begin
      send_request(MODE_RAW, lo, hi, 1'b0, '0, 1'b0);
    end else if (pick < 92) begin
      k = $urandom_range(63);
      case ($urandom_range(9))
        0, 1: span = hi - lo;
        2, 3, 4, 5: span = rand64() >> (63 - k);
        6: span = 64'd1 << k;
        7: span = (64'd1 << k) - 64'd1;
        8: span = -(64'd1 + (rand64() >> (63 - k)));
        default: span = '0;
      endcase
      send_request(MODE_BOUNDED, lo, lo + span, 1'b0, '0, 1'b0);
    end else begin
      send_request(MODE_RESEED, lo, hi, 1'b0, '0, 1'b0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = owed_results.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("value", m_axis_tdata, want.value);
        if (m_axis_tuser[0] !== want.range_error)
          report_mismatch("range_error", 64'(m_axis_tuser), 64'(want.range_error));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    logic [63:0] first_plan [4];
    logic [63:0] second_plan [4];
    int          idle_plan [4];
    int          stall_plan [4];

    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = MODE_FRACTION;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_SEED_FIRST;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    seed_mirror[REG_SEED_FIRST]  = '0;
    seed_mirror[REG_SEED_SECOND] = '0;
    xs_load('0, '0);

    directed_rows = '{
      '{MODE_FRACTION, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
      '{MODE_RAW,      64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
      // A single-value range returns its bound.
      '{MODE_BOUNDED,  64'd5, 64'd5, 1'b1, 64'd5, 1'b0},
      '{MODE_BOUNDED,  MinS,  MinS,  1'b1, MinS,  1'b0},
      '{MODE_BOUNDED,  MaxS,  MaxS,  1'b1, MaxS,  1'b0},
      '{MODE_BOUNDED,  Ones,  Ones,  1'b1, Ones,  1'b0},
      // Lower bound above upper bound.
      '{MODE_BOUNDED,  64'd1, 64'd0, 1'b1, 64'd0, 1'b1},
      '{MODE_BOUNDED,  MaxS,  MinS,  1'b1, 64'd0, 1'b1},
      // Full signed range: span of all ones.
      '{MODE_BOUNDED,  MinS,  MaxS,  1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  64'd0, 64'd15, 1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  64'd0, 64'd16, 1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  64'd0, 64'd2, 1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  -64'd10, 64'd10, 1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  Ones, 64'h4000_0000_0000_0000, 1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  MinS, 64'h8000_0000_0000_0001, 1'b0, 64'd0, 1'b0},
      '{MODE_BOUNDED,  64'd0, MaxS, 1'b0, 64'd0, 1'b0},
      // Reseed gives an empty result; its bounds are ignored.
      '{MODE_RESEED,   64'd0, 64'd0, 1'b1, 64'd0, 1'b0},
      '{MODE_RAW,      64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
      '{MODE_RESEED,   Ones,  Ones,  1'b1, 64'd0, 1'b0},
      '{MODE_FRACTION, Ones,  Ones,  1'b0, 64'd0, 1'b0},
      '{MODE_RAW,      64'd1, 64'd0, 1'b0, 64'd0, 1'b0},
      '{MODE_FRACTION, 64'd1, 64'd0, 1'b0, 64'd0, 1'b0}
    };

    first_plan  = '{Ones, 64'd0, rand64(), rand64()};
    second_plan = '{Ones, rand64(), 64'd0, rand64()};
    idle_plan   = '{0, 70, 0, 17};
    stall_plan  = '{0, 0, 70, 17};

    // Apply reset, then release it.
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].low, directed_rows[i].high,
                   directed_rows[i].typed, directed_rows[i].value,
                   directed_rows[i].range_error);

    // Random phases, each under new seeds and its own idling.
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      write_seed(REG_SEED_FIRST, first_plan[phase]);
      write_seed(REG_SEED_SECOND, second_plan[phase]);
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      send_request(MODE_RESEED, rand64(), rand64(), 1'b1, 64'd0, 1'b0);
      for (int n = 0; n < PhaseItems; n++) begin
        send_random_request();
        // Long receiver hold-off while the sender keeps offering.
        if (phase == 0 && n == 100) hold_left = HoldOffCycles;
        // Sender pause until the block has returned everything.
        if (phase == 1 && n == 150) drain_results();
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/xrg_pkg.sv
hw/rtl/xrg_front.sv
hw/rtl/xrg_queue.sv
hw/rtl/xrg_engine.sv
hw/rtl/xoshiro_range_generator_unit.sv
bench/xoshiro_range_generator_unit_tb.sv
